// File: hw/rtl/rss_pkg.sv
// ----------------------------------------------------------------------------
// rss_pkg
// Shared constants and types for the row sort-and-sum block.
// ----------------------------------------------------------------------------
package rss_pkg;

    localparam int ROW_LEN_DEF   = 16;
    localparam int ELEM_BITS_DEF = 8;

    // Chain control: insert_en lets data ripple up the chain,
    // shift_en moves every held value one cell toward cell 0.
    typedef struct packed {
        logic insert_en;
        logic shift_en;
    } cell_ctrl_t;

endpackage

// File: hw/rtl/rss_cell.sv
// ----------------------------------------------------------------------------
// rss_cell
// One compare-exchange cell of the sorting chain: keeps the smaller value,
// hands the larger one to the next cell, shifts down on emit.
// ----------------------------------------------------------------------------
module rss_cell #(
    parameter int ELEM_BITS = rss_pkg::ELEM_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  rss_pkg::cell_ctrl_t  ctrl,
    input  logic                 in_valid,
    input  logic [ELEM_BITS-1:0] in_data,
    input  logic                 next_valid,
    input  logic [ELEM_BITS-1:0] next_data,
    output logic                 held_valid,
    output logic [ELEM_BITS-1:0] held_data,
    output logic                 pass_valid,
    output logic [ELEM_BITS-1:0] pass_data
);

    logic                 held_valid_reg, held_valid_next;
    logic [ELEM_BITS-1:0] held_data_reg,  held_data_next;
    logic                 pass_valid_reg, pass_valid_next;
    logic [ELEM_BITS-1:0] pass_data_reg,  pass_data_next;

    always_comb
    begin
        held_valid_next = held_valid_reg;
        held_data_next  = held_data_reg;
        pass_valid_next = 1'b0;
        pass_data_next  = pass_data_reg;
        if (ctrl.shift_en)
        begin
            held_valid_next = next_valid;
            held_data_next  = next_data;
        end
        else if (ctrl.insert_en && in_valid)
        begin
            if (!held_valid_reg)
            begin
                held_valid_next = 1'b1;
                held_data_next  = in_data;
            end
            else
            begin
                pass_valid_next = 1'b1;
                if (in_data < held_data_reg)
                begin
                    held_data_next = in_data;
                    pass_data_next = held_data_reg;
                end
                else
                begin
                    pass_data_next = in_data;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            pass_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
            pass_valid_reg <= pass_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_data_reg <= held_data_next;
        pass_data_reg <= pass_data_next;
    end

    assign held_valid = held_valid_reg;
    assign held_data  = held_data_reg;
    assign pass_valid = pass_valid_reg;
    assign pass_data  = pass_data_reg;

endmodule

// File: hw/rtl/row_sort_and_sum.sv
// A row is loaded, then the compare-exchange chain settles, then the row is
// shifted out one element per cycle while the sink is ready (m_tready); the
// first result is registered once the chain has settled.
// Input is not taken while the chain settles or shifts out.
// Reset (rst_n, async, active low) empties the chain and clears the total.
// ----------------------------------------------------------------------------
// row_sort_and_sum
// Collects a row of unsigned elements into a chain of compare-exchange
// cells, then streams the row out in ascending order with its total.
// ----------------------------------------------------------------------------
module row_sort_and_sum #(
    parameter int ROW_LEN   = rss_pkg::ROW_LEN_DEF,
    parameter int ELEM_BITS = rss_pkg::ELEM_BITS_DEF,
    localparam int TOTAL_BITS = ELEM_BITS + $clog2(ROW_LEN),
    localparam int IN_W       = ((ELEM_BITS + 7) / 8) * 8,
    localparam int OUT_W      = ((ELEM_BITS + TOTAL_BITS + 7) / 8) * 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             s_tvalid,
    output logic             s_tready,
    input  logic [IN_W-1:0]  s_tdata,   // value
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [OUT_W-1:0] m_tdata,   // sorted_value, row_total
    output logic             m_tlast    // last
);

    localparam int CNT_BITS = $clog2(ROW_LEN + 1);
    localparam logic [CNT_BITS-1:0] CNT_END = CNT_BITS'(ROW_LEN - 1);

    localparam logic [1:0] ST_LOAD   = 2'd0;
    localparam logic [1:0] ST_SETTLE = 2'd1;
    localparam logic [1:0] ST_EMIT   = 2'd2;

    logic [1:0]            state_reg, state_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic [TOTAL_BITS-1:0] total_reg, total_next;
    logic                  out_valid_reg, out_valid_next;
    logic                  out_last_reg, out_last_next;
    logic [ELEM_BITS-1:0]  out_value_reg, out_value_next;
    logic [TOTAL_BITS-1:0] out_total_reg, out_total_next;

    logic                  in_fire;
    logic                  out_load;
    rss_pkg::cell_ctrl_t   ctrl;

    logic                 chain_valid [ROW_LEN+1];
    logic [ELEM_BITS-1:0] chain_data  [ROW_LEN+1];
    logic                 held_valid  [ROW_LEN+1];
    logic [ELEM_BITS-1:0] held_data   [ROW_LEN+1];

    assign s_tready = (state_reg == ST_LOAD);
    assign in_fire  = s_tvalid && s_tready;
    assign out_load = (state_reg == ST_EMIT) && (!out_valid_reg || m_tready);

    assign ctrl.insert_en = (state_reg != ST_EMIT);
    assign ctrl.shift_en  = out_load;

    assign chain_valid[0]   = in_fire;
    assign chain_data[0]    = s_tdata[ELEM_BITS-1:0];
    assign held_valid[ROW_LEN] = 1'b0;
    assign held_data[ROW_LEN]  = '0;

    for (genvar i = 0; i < ROW_LEN; i++)
    begin : g_cell
        rss_cell #(
            .ELEM_BITS (ELEM_BITS)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .ctrl       (ctrl),
            .in_valid   (chain_valid[i]),
            .in_data    (chain_data[i]),
            .next_valid (held_valid[i+1]),
            .next_data  (held_data[i+1]),
            .held_valid (held_valid[i]),
            .held_data  (held_data[i]),
            .pass_valid (chain_valid[i+1]),
            .pass_data  (chain_data[i+1])
        );
    end

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        total_next     = total_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_last_next  = out_last_reg;
        out_value_next = out_value_reg;
        out_total_next = out_total_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (in_fire)
                begin
                    total_next = total_reg + TOTAL_BITS'(s_tdata[ELEM_BITS-1:0]);
                    if (cnt_reg == CNT_END)
                    begin
                        cnt_next   = '0;
                        state_next = ST_SETTLE;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            ST_SETTLE:
            begin
                if (cnt_reg == CNT_END)
                begin
                    cnt_next   = '0;
                    state_next = ST_EMIT;
                end
                else
                begin
                    cnt_next = cnt_reg + 1'b1;
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next = 1'b1;
                    out_value_next = held_data[0];
                    out_total_next = total_reg;
                    out_last_next  = (cnt_reg == CNT_END);
                    if (cnt_reg == CNT_END)
                    begin
                        cnt_next   = '0;
                        total_next = '0;
                        state_next = ST_LOAD;
                    end
                    else
                    begin
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
                cnt_next   = '0;
                total_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            cnt_reg       <= '0;
            total_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            total_reg     <= total_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_last_reg  <= out_last_next;
        out_value_reg <= out_value_next;
        out_total_reg <= out_total_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tdata  = OUT_W'({out_total_reg, out_value_reg});

endmodule

// File: hw/rtl/rss_checker.sv
// ----------------------------------------------------------------------------
// rss_checker
// Port-level checks for row_sort_and_sum, bound to the top level.
// ----------------------------------------------------------------------------
module rss_checker #(
    parameter int ROW_LEN   = rss_pkg::ROW_LEN_DEF,
    parameter int ELEM_BITS = rss_pkg::ELEM_BITS_DEF,
    localparam int TOTAL_BITS = ELEM_BITS + $clog2(ROW_LEN),
    localparam int OUT_W      = ((ELEM_BITS + TOTAL_BITS + 7) / 8) * 8
) (
    input logic             clk,
    input logic             rst_n,
    input logic             s_tvalid,
    input logic             s_tready,
    input logic             m_tvalid,
    input logic             m_tready,
    input logic [OUT_W-1:0] m_tdata,
    input logic             m_tlast
);

    localparam int CNT_BITS = $clog2(ROW_LEN + 1);
    localparam logic [CNT_BITS-1:0] CNT_END = CNT_BITS'(ROW_LEN - 1);

    logic                  in_fire, out_fire;
    logic [ELEM_BITS-1:0]  out_value;
    logic [TOTAL_BITS-1:0] out_total;

    logic [CNT_BITS-1:0]   in_cnt_reg, out_cnt_reg;
    logic                  pend_reg, in_row_reg;
    logic [ELEM_BITS-1:0]  prev_value_reg;
    logic [TOTAL_BITS-1:0] prev_total_reg;

    assign in_fire   = s_tvalid && s_tready;
    assign out_fire  = m_tvalid && m_tready;
    assign out_value = m_tdata[ELEM_BITS-1:0];
    assign out_total = m_tdata[ELEM_BITS+TOTAL_BITS-1:ELEM_BITS];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_cnt_reg     <= '0;
            out_cnt_reg    <= '0;
            pend_reg       <= 1'b0;
            in_row_reg     <= 1'b0;
            prev_value_reg <= '0;
            prev_total_reg <= '0;
        end
        else
        begin
            if (in_fire)
            begin
                in_cnt_reg <= (in_cnt_reg == CNT_END) ? '0 : in_cnt_reg + 1'b1;
            end
            if (in_fire && in_cnt_reg == CNT_END)
            begin
                pend_reg <= 1'b1;
            end
            else if (out_fire && m_tlast)
            begin
                pend_reg <= 1'b0;
            end
            if (out_fire)
            begin
                out_cnt_reg    <= m_tlast ? '0 : out_cnt_reg + 1'b1;
                in_row_reg     <= !m_tlast;
                prev_value_reg <= out_value;
                prev_total_reg <= out_total;
            end
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire && in_row_reg |-> out_value >= prev_value_reg
                                   && out_total == prev_total_reg)
        else $error("row out of order or total changed within row");

    a_row_len: assert property (@(posedge clk) disable iff (!rst_n)
        out_fire |-> (m_tlast == (out_cnt_reg == CNT_END)))
        else $error("last marker not on final element of row");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg && !(m_tvalid && m_tlast) |-> !s_tready)
        else $error("input taken while a row is still being emitted");

endmodule

bind row_sort_and_sum rss_checker #(
    .ROW_LEN   (ROW_LEN),
    .ELEM_BITS (ELEM_BITS)
) u_rss_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

// File: tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Streams rows of unsigned elements into row_sort_and_sum and checks every
// sorted element, the row total and the end-of-row mark against a local
// exchange-sort predictor. A directed table opens the run, then random rows
// of several value styles follow, under bursty input and a stalling sink.
// ----------------------------------------------------------------------------
module tb;

    localparam int ROWS   = rss_pkg::ROW_LEN_DEF;
    localparam int EW     = rss_pkg::ELEM_BITS_DEF;
    localparam int TW     = EW + $clog2(ROWS);
    localparam int IN_W   = ((EW + 7) / 8) * 8;
    localparam int OUT_W  = ((EW + TW + 7) / 8) * 8;
    localparam int DIR_N  = 25;
    localparam int RAND_N = 231;

    typedef struct {
        logic [EW-1:0] value;
        logic [TW-1:0] total;
        logic          last;
    } sorted_item_t;

    typedef struct packed {
        logic [7:0]  value;
        logic        typed;
        logic [7:0]  exp_value;
        logic [11:0] exp_total;
    } dir_row_t;

    logic             clk      = 1'b0;
    logic             rst_n    = 1'b0;
    logic             s_tvalid = 1'b0;
    logic             s_tready;
    logic [IN_W-1:0]  s_tdata  = '0;  // value
    logic             m_tvalid;
    logic             m_tready = 1'b0;
    logic [OUT_W-1:0] m_tdata;        // sorted_value, row_total
    logic             m_tlast;        // last

    sorted_item_t  sorted_q [$];
    logic [EW-1:0] held_vals [ROWS];
    int            held_count = 0;
    logic [TW-1:0] held_sum   = '0;
    int            fail_count = 0;
    int            burst_left = 0;
    int            rx_cyc     = 0;

    // first row: all maximal, so every result is 255 with total 4080
    dir_row_t dir_tab [DIR_N] = '{
        '{8'hFF, 1'b1, 8'hFF, 12'd4080}, '{8'hFF, 1'b1, 8'hFF, 12'd4080},
        '{8'hFF, 1'b1, 8'hFF, 12'd4080}, '{8'hFF, 1'b1, 8'hFF, 12'd4080},
        '{8'hFF, 1'b1, 8'hFF, 12'd4080}, '{8'hFF, 1'b1, 8'hFF, 12'd4080},
        '{8'hFF, 1'b1, 8'hFF, 12'd4080}, '{8'hFF, 1'b1, 8'hFF, 12'd4080},
        '{8'hFF, 1'b1, 8'hFF, 12'd4080}, '{8'hFF, 1'b1, 8'hFF, 12'd4080},
        '{8'hFF, 1'b1, 8'hFF, 12'd4080}, '{8'hFF, 1'b1, 8'hFF, 12'd4080},
        '{8'hFF, 1'b1, 8'hFF, 12'd4080}, '{8'hFF, 1'b1, 8'hFF, 12'd4080},
        '{8'hFF, 1'b1, 8'hFF, 12'd4080}, '{8'hFF, 1'b1, 8'hFF, 12'd4080},
        '{8'h00, 1'b0, 8'h00, 12'd0},    '{8'hFF, 1'b0, 8'h00, 12'd0},
        '{8'h80, 1'b0, 8'h00, 12'd0},    '{8'h7F, 1'b0, 8'h00, 12'd0},
        '{8'h01, 1'b0, 8'h00, 12'd0},    '{8'hFE, 1'b0, 8'h00, 12'd0},
        '{8'h55, 1'b0, 8'h00, 12'd0},    '{8'hAA, 1'b0, 8'h00, 12'd0},
        '{8'h00, 1'b0, 8'h00, 12'd0}
    };

    row_sort_and_sum dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

    always #2 clk = ~clk;

    // adds one element to the held row; on the last one, sorts the row
    task automatic absorb_value(input logic [EW-1:0] v, output bit done,
                                output logic [EW-1:0] srt [ROWS],
                                output logic [TW-1:0] tot);
        logic [EW-1:0] t;
        if (held_count >= ROWS)
            held_count = 0;
        held_vals[held_count] = v;
        held_sum = held_sum + TW'(v);
        held_count++;
        done = (held_count == ROWS);
        tot  = held_sum;
        if (done)
        begin
            for (int j = 0; j + 1 < ROWS; j++)
                for (int k = j; k < ROWS; k++)
                    if (held_vals[j] > held_vals[k])
                    begin
                        t            = held_vals[j];
                        held_vals[j] = held_vals[k];
                        held_vals[k] = t;
                    end
            held_count = 0;
            held_sum   = '0;
        end
        srt = held_vals;
    endtask

    task automatic send_value(input logic [EW-1:0] v, input logic typed,
                              input logic [EW-1:0] ev, input logic [TW-1:0] et);
        int            gap;
        bit            done;
        logic [EW-1:0] srt [ROWS];
        logic [TW-1:0] tot;
        sorted_item_t  e;
        if (burst_left == 0)
        begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            burst_left = $urandom_range(1, 24);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left--;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= IN_W'(v);
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        absorb_value(v, done, srt, tot);
        if (done)
            for (int i = 0; i < ROWS; i++)
            begin
                e.value = typed ? ev : srt[i];
                e.total = typed ? et : tot;
                e.last  = (i == ROWS - 1);
                sorted_q.push_back(e);
            end
    endtask

    // sink stall pattern: free-running, lightly random, periodic, long holds
    always @(negedge clk)
    begin
        rx_cyc <= rx_cyc + 1;
        case ((rx_cyc >> 7) % 4)
            0:       m_tready <= 1'b1;
            1:       m_tready <= 1'($urandom_range(0, 1));
            2:       m_tready <= (rx_cyc % 4) != 0;
            default: m_tready <= ((rx_cyc >> 3) % 3) != 0;
        endcase
    end

    always @(posedge clk)
    begin
        sorted_item_t  want;
        logic [EW-1:0] got_v;
        logic [TW-1:0] got_t;
        if (rst_n && m_tvalid && m_tready)
        begin
            got_v = m_tdata[EW-1:0];
            got_t = m_tdata[EW+TW-1:EW];
            if (sorted_q.size() == 0)
            begin
                $display("%0t: unexpected item: expected none, actual value=%0d total=%0d last=%0b",
                         $time, got_v, got_t, m_tlast);
                fail_count++;
            end
            else
            begin
                want = sorted_q.pop_front();
                if (got_v !== want.value)
                begin
                    $display("%0t: sorted_value expected %0d actual %0d",
                             $time, want.value, got_v);
                    fail_count++;
                end
                if (got_t !== want.total)
                begin
                    $display("%0t: row_total expected %0d actual %0d",
                             $time, want.total, got_t);
                    fail_count++;
                end
                if (m_tlast !== want.last)
                begin
                    $display("%0t: last expected %0b actual %0b",
                             $time, want.last, m_tlast);
                    fail_count++;
                end
            end
        end
    end

    initial
    begin
        int            n;
        int            style;
        logic [EW-1:0] v;
        n     = 0;
        style = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        for (int i = 0; i < DIR_N; i++)
            send_value(dir_tab[i].value, dir_tab[i].typed,
                       dir_tab[i].exp_value, dir_tab[i].exp_total);

        while (n < RAND_N || held_count != 0)
        begin
            if (held_count == 0)
                style = $urandom_range(0, 5);
            case (style)
                0, 1:    v = EW'($urandom_range(0, 255));
                2:       v = EW'($urandom_range(0, 3));          // many ties
                3:       v = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
                4:       v = EW'($urandom_range(248, 255));
                default: v = 8'h01 << $urandom_range(0, 7);
            endcase
            send_value(v, 1'b0, '0, '0);
            n++;
        end
        @(negedge clk);
        s_tvalid <= 1'b0;

        while (sorted_q.size() != 0)
            @(posedge clk);
        repeat (ROWS * 4) @(posedge clk);

        if (fail_count == 0 && sorted_q.size() == 0)
            $display("[row_sort_and_sum] OK");
        else
            $display("[row_sort_and_sum] ERROR");
        $finish;
    end

    initial
    begin
        #400_000;
        $display("[row_sort_and_sum] ERROR");
        $finish;
    end

endmodule
